FILE: hw/rtl/khc_pkg.sv
package khc_pkg;

    // Hash fold constants
    localparam logic [31:0] HASH_SEED  = 32'h12345678;
    localparam logic [31:0] HASH_MUL   = 32'h5bd1e995;
    localparam int unsigned HASH_SHIFT = 15;

    // Item kinds
    localparam logic KIND_LOAD     = 1'b0;
    localparam logic KIND_CLASSIFY = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_SLOT_TAKEN = 2'd1,
        ST_TOO_LONG   = 2'd2,
        ST_STORE_FULL = 2'd3
    } status_t;

    typedef struct packed {
        logic [31:0] color;
        logic        is_keyword;
        status_t     status;
    } result_t;

    // Result queue
    localparam int unsigned OUTQ_DEPTH = 8;
    localparam int unsigned OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int unsigned OUTQ_PW    = OUTQ_AW + 1;

    // One hash step: xor in the char, multiply mod 2^32, fold down by HASH_SHIFT.
    function automatic logic [31:0] fold_char(input logic [31:0] h, input logic [7:0] c);
        logic [31:0] x;
        logic [31:0] m;
        x = h ^ {24'd0, c};
        m = x * HASH_MUL;
        fold_char = m ^ (m >> HASH_SHIFT);
    endfunction

endpackage

FILE: hw/rtl/khc_ram.sv
module khc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/keyword_hash_classifier_unit.sv
// Keyword hash classifier. Characters stream in one per transfer, each with a
// kind (load or classify), a last marker and, for loads, the keyword color.
// Every character is folded into a 32-bit multiplicative hash and kept in a
// word buffer of MAX_NAME_LEN bytes; a zero character stops the hashing but is
// still kept. The transfer marked last ends the word: its slot (hash mod
// TABLE_SIZE) is probed in the slot table. A load stores the name and color
// and claims the slot, or reports slot taken, name too long or store full. A
// classify compares the stored name and returns its color and is_keyword, or
// default_color on a miss. Exactly one result leaves per word, none for other
// characters. Rate: one character per clock while in_stall is low, set by the
// single hash multiplier in the per-character loop. A word's result goes
// through registered steps after its last character (reciprocal product,
// quotient times table size, reduction with slot table read, name store read,
// compare into the queue) and waits in an eight-entry result queue; outside
// the clearing pass, in_stall rises only when eight results are owed and not
// yet taken. After reset the slot table is cleared one entry per clock, and
// in_stall stays high for that pass; default_color may be written during it.
module keyword_hash_classifier_unit
    import khc_pkg::*;
#(
    parameter int TABLE_SIZE   = 2048,
    parameter int MAX_KEYWORDS = 256,
    parameter int MAX_NAME_LEN = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,

    // character channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  char_code,
    input  logic        last,
    input  logic [31:0] keyword_color,

    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] color,
    output logic        is_keyword,
    output logic [1:0]  status
);

    localparam int TBL_AW  = $clog2(TABLE_SIZE);
    localparam int ENT_W   = $clog2(MAX_KEYWORDS + 1);
    localparam int KW_AW   = (MAX_KEYWORDS > 1) ? $clog2(MAX_KEYWORDS) : 1;
    localparam int LEN_W   = $clog2(MAX_NAME_LEN + 1);
    localparam int NAME_W  = 8 * MAX_NAME_LEN;
    localparam int NREC_W  = NAME_W + LEN_W + 32;
    localparam int QW      = 33 - TBL_AW;

    // Reciprocal for hash mod TABLE_SIZE: q = (h * RECIP) >> (32 + TBL_AW) is
    // the true quotient or one less, so one conditional subtract finishes it.
    localparam logic [65:0] RECIP_NUM = 66'd1 << (32 + TBL_AW);
    localparam logic [32:0] RECIP     = 33'(RECIP_NUM / 66'(TABLE_SIZE));

    // Word pipeline stages after the last character
    localparam int NSTG = 5;
    localparam int SA   = 0;   // final hash held
    localparam int SB   = 1;   // reciprocal product held
    localparam int SC   = 2;   // quotient times table size held, slot read issued
    localparam int SD   = 3;   // slot entry back, decide, store on load
    localparam int SE   = 4;   // stored name back, compare, push result

    //--------------------------------------------------------------------
    // Configuration
    //--------------------------------------------------------------------
    logic [31:0] default_color_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_color_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            default_color_reg <= cfg_data;
        end
    end

    //--------------------------------------------------------------------
    // Slot table clearing pass after reset
    //--------------------------------------------------------------------
    logic              clear_reg;
    logic [TBL_AW-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clear_reg)
        begin
            clr_addr_reg <= clr_addr_reg + TBL_AW'(1);
            if (clr_addr_reg == TBL_AW'(TABLE_SIZE - 1))
            begin
                clear_reg <= 1'b0;
            end
        end
    end

    //--------------------------------------------------------------------
    // Input transfer and result reservation
    //--------------------------------------------------------------------
    logic               accept;
    logic               pop;
    logic [OUTQ_PW-1:0] reserved_reg;
    logic [OUTQ_PW-1:0] reserved_next;

    // Hold off new characters while the table clears or every queue entry is owed
    assign in_stall = clear_reg || (reserved_reg == OUTQ_PW'(OUTQ_DEPTH));
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        reserved_next = reserved_reg;
        if (accept && last)
        begin
            reserved_next = reserved_next + OUTQ_PW'(1);
        end
        if (pop)
        begin
            reserved_next = reserved_next - OUTQ_PW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_reg <= '0;
        end
        else
        begin
            reserved_reg <= reserved_next;
        end
    end

    //--------------------------------------------------------------------
    // Per-character work: hash fold, length count, word buffer
    //--------------------------------------------------------------------
    logic [31:0]      running_hash_reg;
    logic             hash_stopped_reg;
    logic [LEN_W-1:0] word_len_reg;
    logic             word_long_reg;
    logic [7:0]       word_buf_reg [MAX_NAME_LEN];

    logic [31:0]      hash_next;
    logic             stopped_next;
    logic [LEN_W-1:0] len_next;
    logic             long_next;
    logic [7:0]       buf_next [MAX_NAME_LEN];
    logic [NAME_W-1:0] name_next;

    always_comb
    begin
        // A zero character freezes the hash for the rest of the word
        if (hash_stopped_reg || (char_code == 8'd0))
        begin
            hash_next = running_hash_reg;
        end
        else
        begin
            hash_next = fold_char(running_hash_reg, char_code);
        end
        stopped_next = hash_stopped_reg || (char_code == 8'd0);

        // Drop characters past the buffer and flag the word
        if (word_len_reg < LEN_W'(MAX_NAME_LEN))
        begin
            len_next  = word_len_reg + LEN_W'(1);
            long_next = word_long_reg;
        end
        else
        begin
            len_next  = word_len_reg;
            long_next = 1'b1;
        end

        for (int i = 0; i < MAX_NAME_LEN; i++)
        begin
            buf_next[i] = (word_len_reg == LEN_W'(i)) ? char_code : word_buf_reg[i];
            name_next[8*i +: 8] = buf_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_hash_reg <= HASH_SEED;
            hash_stopped_reg <= 1'b0;
            word_len_reg     <= '0;
            word_long_reg    <= 1'b0;
        end
        else if (accept)
        begin
            if (last)
            begin
                // Word handed to the pipeline: start the next one fresh
                running_hash_reg <= HASH_SEED;
                hash_stopped_reg <= 1'b0;
                word_len_reg     <= '0;
                word_long_reg    <= 1'b0;
            end
            else
            begin
                running_hash_reg <= hash_next;
                hash_stopped_reg <= stopped_next;
                word_len_reg     <= len_next;
                word_long_reg    <= long_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < MAX_NAME_LEN; i++)
            begin
                word_buf_reg[i] <= buf_next[i];
            end
        end
    end

    //--------------------------------------------------------------------
    // Word pipeline: the word itself travels along with its slot lookup
    //--------------------------------------------------------------------
    logic              stg_valid_reg  [NSTG];
    logic              stg_kind_reg   [NSTG];
    logic              stg_long_reg   [NSTG];
    logic [LEN_W-1:0]  stg_len_reg    [NSTG];
    logic [NAME_W-1:0] stg_name_reg   [NSTG];
    logic [31:0]       stg_kcolor_reg [NSTG];

    logic [31:0]       a_hash_reg;
    logic [31:0]       b_hash_reg;
    logic [QW-1:0]     b_q_reg;
    logic [31:0]       c_hash_reg;
    logic [31:0]       c_qt_reg;
    logic [TBL_AW-1:0] d_slot_reg;
    logic [TBL_AW-1:0] e_slot_reg;
    logic              e_wrote_reg;
    logic [ENT_W-1:0]  e_entry_reg;
    logic              e_probe_reg;
    status_t           e_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NSTG; s++)
            begin
                stg_valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            stg_valid_reg[SA] <= accept && last;
            for (int s = 1; s < NSTG; s++)
            begin
                stg_valid_reg[s] <= stg_valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        stg_kind_reg[SA]   <= kind;
        stg_long_reg[SA]   <= long_next;
        stg_len_reg[SA]    <= len_next;
        stg_name_reg[SA]   <= name_next;
        stg_kcolor_reg[SA] <= keyword_color;
        for (int s = 1; s < NSTG; s++)
        begin
            stg_kind_reg[s]   <= stg_kind_reg[s-1];
            stg_long_reg[s]   <= stg_long_reg[s-1];
            stg_len_reg[s]    <= stg_len_reg[s-1];
            stg_name_reg[s]   <= stg_name_reg[s-1];
            stg_kcolor_reg[s] <= stg_kcolor_reg[s-1];
        end
    end

    //--------------------------------------------------------------------
    // Slot = hash mod TABLE_SIZE over stages A to C
    //--------------------------------------------------------------------
    logic [64:0]       q_prod;
    logic [63:0]       qt_prod;
    logic [31:0]       c_diff;
    logic [32:0]       c_diff2;
    logic [TBL_AW-1:0] c_slot;

    always_comb
    begin
        q_prod  = 65'(a_hash_reg) * 65'(RECIP);
        qt_prod = 64'(b_q_reg) * 64'(TABLE_SIZE);
        // Remainder is below twice the table size: subtract once more if needed
        c_diff  = c_hash_reg - c_qt_reg;
        c_diff2 = {1'b0, c_diff} - 33'(TABLE_SIZE);
        c_slot  = c_diff2[32] ? c_diff[TBL_AW-1:0] : c_diff2[TBL_AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (accept && last)
        begin
            a_hash_reg <= hash_next;
        end
        b_hash_reg <= a_hash_reg;
        b_q_reg    <= q_prod[32 + TBL_AW +: QW];
        c_hash_reg <= b_hash_reg;
        c_qt_reg   <= qt_prod[31:0];
        d_slot_reg <= c_slot;
    end

    //--------------------------------------------------------------------
    // Stage D: slot entry, load decision, stores
    //--------------------------------------------------------------------
    logic [ENT_W-1:0]  kw_count_reg;
    logic [ENT_W-1:0]  slot_rdata;
    logic [ENT_W-1:0]  d_entry;
    logic [ENT_W-1:0]  d_kidx;
    logic [ENT_W-1:0]  d_new_entry;
    logic              fwd_hit;
    logic              d_is_load;
    logic              d_write;
    logic              d_write_en;
    logic              d_probe;
    status_t           d_status;

    logic              slot_we;
    logic [TBL_AW-1:0] slot_waddr;
    logic [ENT_W-1:0]  slot_wdata;
    logic [KW_AW-1:0]  name_raddr;
    logic [NREC_W-1:0] name_rdata;

    always_comb
    begin
        // The word one stage ahead may have just claimed this slot
        fwd_hit     = stg_valid_reg[SE] && e_wrote_reg && (e_slot_reg == d_slot_reg);
        d_entry     = fwd_hit ? e_entry_reg : slot_rdata;
        d_kidx      = d_entry - ENT_W'(1);
        d_new_entry = kw_count_reg + ENT_W'(1);
        d_is_load   = (stg_kind_reg[SD] == KIND_LOAD);
        d_status    = ST_OK;
        d_write     = 1'b0;
        if (d_is_load)
        begin
            if (stg_long_reg[SD])
            begin
                d_status = ST_TOO_LONG;
            end
            else if (kw_count_reg >= ENT_W'(MAX_KEYWORDS))
            begin
                d_status = ST_STORE_FULL;
            end
            else if (d_entry != '0)
            begin
                d_status = ST_SLOT_TAKEN;
            end
            else
            begin
                d_write = 1'b1;
            end
        end
        d_write_en = stg_valid_reg[SD] && d_write;
        d_probe    = !d_is_load && (d_entry != '0) && !stg_long_reg[SD];
        name_raddr = d_kidx[KW_AW-1:0];

        // The clearing pass owns the write port until it ends
        slot_we    = clear_reg || d_write_en;
        slot_waddr = clear_reg ? clr_addr_reg : d_slot_reg;
        slot_wdata = clear_reg ? '0 : d_new_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kw_count_reg <= '0;
        end
        else if (d_write_en)
        begin
            kw_count_reg <= d_new_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_wrote_reg <= 1'b0;
        end
        else
        begin
            e_wrote_reg <= d_write_en;
        end
    end

    always_ff @(posedge clk)
    begin
        e_slot_reg   <= d_slot_reg;
        e_entry_reg  <= d_new_entry;
        e_probe_reg  <= d_probe;
        e_status_reg <= d_status;
    end

    khc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_SIZE)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (c_slot),
        .rdata (slot_rdata)
    );

    khc_ram #(
        .WIDTH (NREC_W),
        .DEPTH (MAX_KEYWORDS)
    ) u_name_ram (
        .clk   (clk),
        .we    (d_write_en),
        .waddr (kw_count_reg[KW_AW-1:0]),
        .wdata ({stg_name_reg[SD], stg_len_reg[SD], stg_kcolor_reg[SD]}),
        .raddr (name_raddr),
        .rdata (name_rdata)
    );

    //--------------------------------------------------------------------
    // Stage E: exact compare of length and the bytes within it
    //--------------------------------------------------------------------
    logic [NAME_W-1:0] e_name;
    logic [LEN_W-1:0]  e_len;
    logic [31:0]       e_color;
    logic              e_mismatch;
    logic              e_hit;
    result_t           e_result;

    always_comb
    begin
        {e_name, e_len, e_color} = name_rdata;
        e_mismatch = (e_len != stg_len_reg[SE]);
        for (int i = 0; i < MAX_NAME_LEN; i++)
        begin
            if ((LEN_W'(i) < stg_len_reg[SE])
                && (e_name[8*i +: 8] != stg_name_reg[SE][8*i +: 8]))
            begin
                e_mismatch = 1'b1;
            end
        end
        e_hit               = e_probe_reg && !e_mismatch;
        e_result.color      = e_hit ? e_color : default_color_reg;
        e_result.is_keyword = e_hit;
        e_result.status     = e_status_reg;
    end

    //--------------------------------------------------------------------
    // Result queue; room for every pushed result was reserved at input
    //--------------------------------------------------------------------
    result_t            outq_reg [OUTQ_DEPTH];
    logic [OUTQ_PW-1:0] wr_ptr_reg;
    logic [OUTQ_PW-1:0] rd_ptr_reg;
    logic [OUTQ_PW-1:0] outq_used;
    result_t            head;

    assign outq_used  = wr_ptr_reg - rd_ptr_reg;
    assign out_valid  = (wr_ptr_reg != rd_ptr_reg);
    assign pop        = out_valid && !out_stall;
    assign head       = outq_reg[rd_ptr_reg[OUTQ_AW-1:0]];
    assign color      = head.color;
    assign is_keyword = head.is_keyword;
    assign status     = head.status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (stg_valid_reg[SE])
            begin
                wr_ptr_reg <= wr_ptr_reg + OUTQ_PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + OUTQ_PW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_valid_reg[SE])
        begin
            outq_reg[wr_ptr_reg[OUTQ_AW-1:0]] <= e_result;
        end
    end

`ifndef SYNTHESIS
    // A finished word always finds a free queue entry
    a_outq_room: assert property (@(posedge clk) disable iff (!rst_n)
        stg_valid_reg[SE] |-> (outq_used < OUTQ_PW'(OUTQ_DEPTH)))
        else $error("result pushed into a full queue");

    // Reservations cover every result already queued
    a_reserve_cover: assert property (@(posedge clk) disable iff (!rst_n)
        (outq_used <= reserved_reg) && (reserved_reg <= OUTQ_PW'(OUTQ_DEPTH)))
        else $error("result reservation count out of step with queue");

    // No keyword is stored while the slot table is still being cleared
    a_no_store_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        d_write_en |-> !clear_reg)
        else $error("keyword store during slot table clear");

    // A keyword match only comes from a classify, which reports OK
    a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_keyword) |-> (status == ST_OK))
        else $error("keyword match with error status");
`endif

endmodule
